// ===== rtl/linear_probe_hash_map_assert.svh =====
// Assertion macros for the checker file.
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH

// Checked on every edge outside reset.
`define LPHM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define LPHM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/lphm_pkg.sv =====
package lphm_pkg;

    // default sizing
    localparam int DEF_TABLE_SLOTS = 1024;
    localparam int DEF_VALUE_BITS  = 32;
    localparam int DEF_KEY_BITS    = 64;

    // home slot hash
    localparam logic [63:0] GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;
    localparam int          HASH_SHIFT  = 5;

    // operation codes
    localparam logic [1:0] OP_LOOKUP   = 2'd0;
    localparam logic [1:0] OP_ACCESS   = 2'd1;
    localparam logic [1:0] OP_ERASE    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // slot status codes
    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_ERASED = 2'd1;
    localparam logic [1:0] ST_USED   = 2'd2;

endpackage

// ===== rtl/linear_probe_hash_map.sv =====
// Open-addressed key/value table with linear probing and tombstones. Each request
// (lookup, access = find-or-insert, erase) hashes its key to a home slot and walks
// the slots one by one through a status memory and a key/value memory with
// registered reads. Each probed slot passes through a probe state and a check
// state; a request also passes through accept, hash and resolve states, a move
// state when a found entry moves into an earlier tombstone, and a finish state that
// hands the result to the output register. A result may wait in the output register
// while the next request is taken. After reset the status memory is cleared to free,
// one slot a cycle, and no request is taken during that pass. TABLE_SLOTS must be a
// power of two.
module linear_probe_hash_map #(
    parameter int TABLE_SLOTS = lphm_pkg::DEF_TABLE_SLOTS,
    parameter int VALUE_BITS  = lphm_pkg::DEF_VALUE_BITS,
    parameter int KEY_BITS    = lphm_pkg::DEF_KEY_BITS,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS),
    parameter int CNT_W       = $clog2(TABLE_SLOTS + 1),
    parameter int IN_W        = ((3 + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((3 + VALUE_BITS + SLOT_W + CNT_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // op[1:0], key, write_enable, write_value, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // found, created, entry_value, slot, table_full, live_entries, zero pad
    output logic [OUT_W-1:0] m_tdata
);
    import lphm_pkg::*;

    localparam int HB   = SLOT_W + HASH_SHIFT;
    localparam int KV_W = KEY_BITS + VALUE_BITS;
    localparam int RES_W = 3 + VALUE_BITS + SLOT_W + CNT_W;
    localparam logic [HB-1:0] MULT_LO = GOLDEN_MULT[HB-1:0];
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_HASH    = 3'd2;
    localparam logic [2:0] S_PROBE   = 3'd3;
    localparam logic [2:0] S_CHECK   = 3'd4;
    localparam logic [2:0] S_RESOLVE = 3'd5;
    localparam logic [2:0] S_MOVE    = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    logic [2:0] state_reg, state_next;

    // memories
    logic [1:0]      st_mem [TABLE_SLOTS];
    logic [KV_W-1:0] kv_mem [TABLE_SLOTS];
    logic [1:0]      st_rd_reg;
    logic [KV_W-1:0] kv_rd_reg;

    // request
    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic                  we_reg;
    logic [VALUE_BITS-1:0] wv_reg;

    // probe tracking
    logic [SLOT_W-1:0]     pos_reg, iter_reg, clr_reg;
    logic                  tomb_vld_reg, match_vld_reg, stop_vld_reg;
    logic [SLOT_W-1:0]     tomb_reg, match_reg, stop_reg;
    logic [VALUE_BITS-1:0] match_val_reg;

    // result
    logic                  found_reg, created_reg, full_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [CNT_W-1:0]      live_reg;
    logic                  m_valid_reg;
    logic [RES_W-1:0]      m_data_reg;

    // hash
    logic [63:0]   kx, h64;
    logic [HB-1:0] prod;

    // resolve outcome
    logic                  found_n, created_n, full_n, move_n;
    logic [VALUE_BITS-1:0] value_n, val_sel;
    logic [SLOT_W-1:0]     slot_n;
    logic [CNT_W-1:0]      live_n;
    logic                  kv_we, st_we;
    logic [SLOT_W-1:0]     kv_addr, st_addr;
    logic [KV_W-1:0]       kv_wdata;
    logic [1:0]            st_wdata;

    logic key_hit;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_data_reg);

    // home slot: only the low HB product bits reach the index
    assign kx   = 64'(key_reg);
    assign h64  = kx ^ (kx >> HASH_SHIFT);
    assign prod = h64[HB-1:0] * MULT_LO;

    assign key_hit = (st_rd_reg == ST_USED) && (kv_rd_reg[KEY_BITS-1:0] == key_reg);

    // resolve: decide the outcome and the first memory write
    always_comb begin
        found_n   = 1'b0;
        created_n = 1'b0;
        full_n    = 1'b0;
        move_n    = 1'b0;
        value_n   = '0;
        slot_n    = '0;
        live_n    = live_reg;
        kv_we     = 1'b0;
        kv_addr   = match_reg;
        kv_wdata  = {wv_reg, key_reg};
        st_we     = 1'b0;
        st_addr   = match_reg;
        st_wdata  = ST_USED;
        val_sel   = (op_reg == OP_ACCESS && we_reg) ? wv_reg : match_val_reg;
        case (op_reg)
            OP_LOOKUP, OP_ACCESS: begin
                if (match_vld_reg) begin
                    found_n = 1'b1;
                    slot_n  = match_reg;
                    if (tomb_vld_reg) begin
                        // pull the entry forward into the first tombstone
                        move_n   = 1'b1;
                        slot_n   = tomb_reg;
                        kv_we    = 1'b1;
                        kv_addr  = tomb_reg;
                        kv_wdata = {val_sel, key_reg};
                        st_we    = 1'b1;
                        st_addr  = tomb_reg;
                    end else if (op_reg == OP_ACCESS && we_reg) begin
                        kv_we = 1'b1;
                    end
                    if (op_reg == OP_ACCESS) begin
                        value_n = val_sel;
                    end
                end else if (op_reg == OP_ACCESS) begin
                    if (tomb_vld_reg || stop_vld_reg) begin
                        created_n = 1'b1;
                        slot_n    = tomb_vld_reg ? tomb_reg : stop_reg;
                        value_n   = we_reg ? wv_reg : '0;
                        kv_we     = 1'b1;
                        kv_addr   = slot_n;
                        kv_wdata  = {value_n, key_reg};
                        st_we     = 1'b1;
                        st_addr   = slot_n;
                        live_n    = live_reg + CNT_W'(1);
                    end else begin
                        full_n = 1'b1;
                    end
                end
            end
            OP_ERASE: begin
                if (match_vld_reg) begin
                    found_n  = 1'b1;
                    slot_n   = match_reg;
                    st_we    = 1'b1;
                    st_wdata = ST_ERASED;
                    if (live_reg != '0) begin
                        live_n = live_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (clr_reg == LAST_SLOT) state_next = S_IDLE;
            S_IDLE:    if (s_tvalid) state_next = S_HASH;
            S_HASH:    state_next = S_PROBE;
            S_PROBE:   state_next = S_CHECK;
            S_CHECK: begin
                if (st_rd_reg == ST_FREE || key_hit || iter_reg == LAST_SLOT) begin
                    state_next = S_RESOLVE;
                end else begin
                    state_next = S_PROBE;
                end
            end
            S_RESOLVE: state_next = move_n ? S_MOVE : S_FINISH;
            S_MOVE:    state_next = S_FINISH;
            S_FINISH:  if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (state_reg == S_RESOLVE) begin
                live_reg <= live_n;
            end
            if (state_reg == S_FINISH && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, probe walk and result
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                op_reg  <= s_tdata[1:0];
                key_reg <= s_tdata[2 +: KEY_BITS];
                we_reg  <= s_tdata[2 + KEY_BITS];
                wv_reg  <= s_tdata[3 + KEY_BITS +: VALUE_BITS];
            end
            S_HASH: begin
                pos_reg       <= prod[HASH_SHIFT +: SLOT_W];
                iter_reg      <= '0;
                tomb_vld_reg  <= 1'b0;
                match_vld_reg <= 1'b0;
                stop_vld_reg  <= 1'b0;
            end
            S_CHECK: begin
                if (st_rd_reg == ST_FREE) begin
                    stop_vld_reg <= 1'b1;
                    stop_reg     <= pos_reg;
                end else if (key_hit) begin
                    match_vld_reg <= 1'b1;
                    match_reg     <= pos_reg;
                    match_val_reg <= kv_rd_reg[KEY_BITS +: VALUE_BITS];
                end else begin
                    if (st_rd_reg == ST_ERASED && !tomb_vld_reg) begin
                        tomb_vld_reg <= 1'b1;
                        tomb_reg     <= pos_reg;
                    end
                    pos_reg  <= pos_reg + SLOT_W'(1);
                    iter_reg <= iter_reg + SLOT_W'(1);
                end
            end
            S_RESOLVE: begin
                found_reg   <= found_n;
                created_reg <= created_n;
                full_reg    <= full_n;
                value_reg   <= value_n;
                slot_reg    <= slot_n;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= {live_reg, full_reg, slot_reg, value_reg,
                                   created_reg, found_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // status memory: clearing pass, resolve write, tombstone of a moved entry
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            st_mem[clr_reg] <= ST_FREE;
        end else if (state_reg == S_RESOLVE && st_we) begin
            st_mem[st_addr] <= st_wdata;
        end else if (state_reg == S_MOVE) begin
            st_mem[match_reg] <= ST_ERASED;
        end
        st_rd_reg <= st_mem[pos_reg];
    end

    // key/value memory
    always_ff @(posedge aclk) begin
        if (state_reg == S_RESOLVE && kv_we) begin
            kv_mem[kv_addr] <= kv_wdata;
        end
        kv_rd_reg <= kv_mem[pos_reg];
    end

endmodule

// ===== rtl/lphm_checker.sv =====
module lphm_checker #(
    parameter int TABLE_SLOTS = lphm_pkg::DEF_TABLE_SLOTS,
    parameter int VALUE_BITS  = lphm_pkg::DEF_VALUE_BITS,
    parameter int KEY_BITS    = lphm_pkg::DEF_KEY_BITS,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS),
    parameter int CNT_W       = $clog2(TABLE_SLOTS + 1),
    parameter int IN_W        = ((3 + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((3 + VALUE_BITS + SLOT_W + CNT_W + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    `include "linear_probe_hash_map_assert.svh"

    localparam int FULL_BIT = 2 + VALUE_BITS + SLOT_W;

    logic r_found, r_created, r_full;
    logic [CNT_W-1:0] r_live;
    logic in_busy;

    assign r_found   = m_tdata[0];
    assign r_created = m_tdata[1];
    assign r_full    = m_tdata[FULL_BIT];
    assign r_live    = m_tdata[FULL_BIT + 1 +: CNT_W];
    assign in_busy   = s_tvalid && s_tready && (s_tdata[IN_W-1:0] == s_tdata);

    `LPHM_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid && !s_tready, "busy after reset")
    `LPHM_ASSERT(a_result_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")
    `LPHM_ASSERT(a_flags_exclusive, m_tvalid |-> !(r_created && r_found) && !(r_full && (r_found || r_created)), "conflicting flags")
    `LPHM_ASSERT(a_created_live, m_tvalid && r_created |-> r_live != '0, "insert left table empty")
    `LPHM_ASSERT(a_one_in_flight, in_busy |=> !s_tready, "request taken back to back")

endmodule

bind linear_probe_hash_map lphm_checker #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .VALUE_BITS (VALUE_BITS),
    .KEY_BITS   (KEY_BITS)
) u_lphm_checker (.*);
